// ===== src/madt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MADT interrupt routing unit.
// Used by madt_ctrl, madt_dp, the top level and the checker; no dependencies.
package madt_pkg;

  localparam int DEF_MAX_IOAPICS   = 8;
  localparam int DEF_MAX_OVERRIDES = 16;
  localparam int PIN_WINDOW        = 24;
  localparam int ENTRY_START       = 44;

  // request kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_ISA  = 2'd1;
  localparam logic [1:0] KIND_GSI  = 2'd2;

  // result kinds
  localparam logic [1:0] RK_TABLE = 2'd0;
  localparam logic [1:0] RK_ISA   = 2'd1;
  localparam logic [1:0] RK_GSI   = 2'd2;

  // MADT entry types
  localparam logic [7:0] ENT_LAPIC     = 8'd0;
  localparam logic [7:0] ENT_IOAPIC    = 8'd1;
  localparam logic [7:0] ENT_OVERRIDE  = 8'd2;
  localparam logic [7:0] ENT_LAPIC_OVR = 8'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTE,
    ST_APPLY,
    ST_FIN,
    ST_ISA,
    ST_GSI_LOAD,
    ST_GSI_SCAN,
    ST_GSI_TEST,
    ST_DONE
  } madt_state_t;

  typedef struct packed {
    logic capture;
    logic byte_step;
    logic apply;
    logic fin;
    logic isa_step;
    logic gsi_load;
    logic gsi_scan;
    logic gsi_test;
  } madt_cmd_t;

  typedef struct packed {
    logic byte_ignored;
    logic entry_done;
    logic table_end;
    logic end_pend;
    logic isa_done;
    logic gsi_none;
    logic scan_last;
    logic gsi_hit;
  } madt_sts_t;

endpackage

// ===== src/madt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the MADT interrupt routing unit.
// Depends on madt_pkg; drives madt_dp through command/status structs.
module madt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          kind,
  input  madt_pkg::madt_sts_t sts,
  output madt_pkg::madt_cmd_t cmd,
  output logic                busy,
  output logic                strobe
);

  madt_pkg::madt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= madt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != madt_pkg::ST_IDLE);
    strobe     = 1'b0;
    unique case (state)
      madt_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          priority case (kind)
            madt_pkg::KIND_BYTE: state_next = madt_pkg::ST_BYTE;
            madt_pkg::KIND_ISA:  state_next = madt_pkg::ST_ISA;
            madt_pkg::KIND_GSI:  state_next = madt_pkg::ST_GSI_LOAD;
            default:             state_next = madt_pkg::ST_IDLE;
          endcase
        end
      end
      madt_pkg::ST_BYTE: begin
        cmd.byte_step = 1'b1;
        priority if (sts.byte_ignored) state_next = madt_pkg::ST_IDLE;
        else if (sts.entry_done)       state_next = madt_pkg::ST_APPLY;
        else if (sts.table_end)        state_next = madt_pkg::ST_FIN;
        else                           state_next = madt_pkg::ST_IDLE;
      end
      madt_pkg::ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = sts.end_pend ? madt_pkg::ST_FIN : madt_pkg::ST_IDLE;
      end
      madt_pkg::ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = madt_pkg::ST_DONE;
      end
      madt_pkg::ST_ISA: begin
        cmd.isa_step = 1'b1;
        if (sts.isa_done) state_next = madt_pkg::ST_DONE;
      end
      madt_pkg::ST_GSI_LOAD: begin
        cmd.gsi_load = 1'b1;
        state_next   = sts.gsi_none ? madt_pkg::ST_DONE : madt_pkg::ST_GSI_SCAN;
      end
      madt_pkg::ST_GSI_SCAN: begin
        cmd.gsi_scan = 1'b1;
        if (sts.scan_last) state_next = madt_pkg::ST_GSI_TEST;
      end
      madt_pkg::ST_GSI_TEST: begin
        cmd.gsi_test = 1'b1;
        state_next   = sts.gsi_hit ? madt_pkg::ST_DONE : madt_pkg::ST_GSI_LOAD;
      end
      madt_pkg::ST_DONE: begin
        strobe     = 1'b1;
        state_next = madt_pkg::ST_IDLE;
      end
      default: state_next = madt_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/madt_dp.sv =====
`timescale 1ns / 1ps
// Datapath: byte parser, entry buffer, IOAPIC/override tables, query walkers
// and result registers. Depends on madt_pkg; commanded by madt_ctrl.
module madt_dp #(
  parameter int MAX_IOAPICS   = madt_pkg::DEF_MAX_IOAPICS,
  parameter int MAX_OVERRIDES = madt_pkg::DEF_MAX_OVERRIDES
) (
  input  logic                clk,
  input  logic                rst,
  input  madt_pkg::madt_cmd_t cmd,
  output madt_pkg::madt_sts_t sts,
  input  logic [1:0]          kind,
  input  logic                first_byte,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          isa_irq,
  input  logic [31:0]         gsi_query,
  output logic [1:0]          result_kind,
  output logic                table_valid,
  output logic [63:0]         lapic_addr,
  output logic                legacy_pic,
  output logic [7:0]          bsp_apic_id,
  output logic                found,
  output logic [31:0]         resolved_gsi,
  output logic [15:0]         override_flags,
  output logic [2:0]          ioapic_slot,
  output logic [7:0]          io_apic_id,
  output logic [31:0]         ioapic_address,
  output logic [4:0]          pin_number
);

  localparam int IO_CW = $clog2(MAX_IOAPICS + 1);
  localparam int IO_IW = (MAX_IOAPICS > 1) ? $clog2(MAX_IOAPICS) : 1;
  localparam int OV_CW = $clog2(MAX_OVERRIDES + 1);
  localparam int OV_IW = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;

  // parser state
  logic [31:0] byte_offset, table_length;
  logic [7:0]  running_sum, entry_position;
  logic        entries_stopped, end_pend;
  logic [63:0] lapic_base;
  logic        pic_flag;
  logic [7:0]  boot_apic;
  logic [7:0]  entry_buffer [16];

  // tables
  logic [7:0]  io_apic_ids  [MAX_IOAPICS];
  logic [31:0] ioapic_addrs [MAX_IOAPICS];
  logic [31:0] ioapic_bases [MAX_IOAPICS];
  logic [IO_CW-1:0] ioapic_total;
  logic [7:0]  override_sources    [MAX_OVERRIDES];
  logic [31:0] override_gsis       [MAX_OVERRIDES];
  logic [15:0] override_flag_words [MAX_OVERRIDES];
  logic [OV_CW-1:0] override_total;

  // request and walk registers
  logic [7:0]       b_q, irq_q;
  logic [31:0]      gsi_q;
  logic [OV_CW-1:0] ov_cnt;
  logic [IO_CW-1:0] io_cnt, j_cnt;
  logic [31:0]      base_i;
  logic [4:0]       span;

  // byte-step decode
  logic        ignored, tbl_end, in_entry, ent_done;
  logic [32:0] off_inc;
  logic [31:0] len_now;
  logic [8:0]  elen, pos_inc;

  always_comb begin
    ignored  = (byte_offset >= 32'd8) && (byte_offset >= table_length);
    off_inc  = {1'b0, byte_offset} + 33'd1;
    // the top length byte lands on offset 7, the first offset that can end the table
    len_now  = (byte_offset == 32'd7) ? {b_q, table_length[23:0]} : table_length;
    tbl_end  = (byte_offset >= 32'd7) && (off_inc >= {1'b0, len_now});
    in_entry = (byte_offset >= 32'(madt_pkg::ENTRY_START)) && !entries_stopped;
    elen     = {1'b0, (entry_position == 8'd1) ? b_q : entry_buffer[1]};
    if (elen < 9'd2) elen = 9'd2;
    pos_inc  = {1'b0, entry_position} + 9'd1;
    ent_done = in_entry && (entry_position != 8'd0) &&
               !((entry_position == 8'd1) && (b_q == 8'd0)) && (pos_inc >= elen);
  end

  // query decode
  logic [OV_IW-1:0] ov_idx;
  logic [IO_IW-1:0] io_idx, j_idx, rd_idx;
  logic             isa_end, isa_hit, gsi_end, gsi_hit;
  logic [31:0]      rd_base, diff;
  logic [32:0]      win_end;

  always_comb begin
    ov_idx  = ov_cnt[OV_IW-1:0];
    io_idx  = io_cnt[IO_IW-1:0];
    j_idx   = j_cnt[IO_IW-1:0];
    rd_idx  = cmd.gsi_scan ? j_idx : io_idx;
    rd_base = ioapic_bases[rd_idx];
    diff    = rd_base - base_i;
    isa_end = (ov_cnt == override_total);
    isa_hit = !isa_end && (override_sources[ov_idx] == irq_q);
    gsi_end = (io_cnt == ioapic_total);
    win_end = {1'b0, base_i} + {28'd0, span};
    gsi_hit = (gsi_q >= base_i) && ({1'b0, gsi_q} < win_end);
  end

  always_comb begin
    sts              = '0;
    sts.byte_ignored = ignored;
    sts.entry_done   = ent_done;
    sts.table_end    = tbl_end;
    sts.end_pend     = end_pend;
    sts.isa_done     = isa_end || isa_hit;
    sts.gsi_none     = gsi_end;
    sts.scan_last    = (j_cnt == ioapic_total - IO_CW'(1));
    sts.gsi_hit      = gsi_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      table_length    <= '0;
      running_sum     <= '0;
      entry_position  <= '0;
      entries_stopped <= 1'b0;
      end_pend        <= 1'b0;
      lapic_base      <= '0;
      pic_flag        <= 1'b0;
      boot_apic       <= '0;
      ioapic_total    <= '0;
      override_total  <= '0;
    end else begin
      if (cmd.capture) begin
        b_q    <= data_byte;
        irq_q  <= isa_irq;
        gsi_q  <= gsi_query;
        ov_cnt <= '0;
        io_cnt <= '0;
        if (kind == madt_pkg::KIND_BYTE && first_byte) begin
          byte_offset     <= '0;
          table_length    <= '0;
          running_sum     <= '0;
          entry_position  <= '0;
          entries_stopped <= 1'b0;
          lapic_base      <= '0;
          pic_flag        <= 1'b0;
          boot_apic       <= '0;
          ioapic_total    <= '0;
          override_total  <= '0;
        end
      end

      if (cmd.byte_step && !ignored) begin
        running_sum <= running_sum + b_q;
        byte_offset <= off_inc[31:0];
        end_pend    <= tbl_end;
        if (byte_offset >= 32'd4 && byte_offset <= 32'd7)
          table_length[8*byte_offset[1:0] +: 8] <= b_q;
        else if (byte_offset >= 32'd36 && byte_offset <= 32'd39)
          lapic_base[8*byte_offset[1:0] +: 8] <= b_q;
        else if (byte_offset == 32'd40)
          pic_flag <= b_q[0];
        else if (in_entry) begin
          if (entry_position < 8'd16) entry_buffer[entry_position[3:0]] <= b_q;
          priority if (entry_position == 8'd0) entry_position <= 8'd1;
          else if (entry_position == 8'd1 && b_q == 8'd0) entries_stopped <= 1'b1;
          else if (ent_done) entry_position <= '0;
          else entry_position <= pos_inc[7:0];
        end
      end

      if (cmd.apply) begin
        priority if (entry_buffer[0] == madt_pkg::ENT_LAPIC && entry_buffer[1] >= 8'd8) begin
          if (entry_buffer[4][0] && boot_apic == 8'd0) boot_apic <= entry_buffer[3];
        end else if (entry_buffer[0] == madt_pkg::ENT_IOAPIC && entry_buffer[1] >= 8'd12) begin
          if (ioapic_total < IO_CW'(MAX_IOAPICS)) begin
            io_apic_ids[ioapic_total[IO_IW-1:0]]  <= entry_buffer[2];
            ioapic_addrs[ioapic_total[IO_IW-1:0]] <= {entry_buffer[7], entry_buffer[6],
                                                      entry_buffer[5], entry_buffer[4]};
            ioapic_bases[ioapic_total[IO_IW-1:0]] <= {entry_buffer[11], entry_buffer[10],
                                                      entry_buffer[9], entry_buffer[8]};
            ioapic_total <= ioapic_total + IO_CW'(1);
          end
        end else if (entry_buffer[0] == madt_pkg::ENT_OVERRIDE && entry_buffer[1] >= 8'd10) begin
          if (override_total < OV_CW'(MAX_OVERRIDES)) begin
            override_sources[override_total[OV_IW-1:0]]    <= entry_buffer[3];
            override_gsis[override_total[OV_IW-1:0]]       <= {entry_buffer[7], entry_buffer[6],
                                                               entry_buffer[5], entry_buffer[4]};
            override_flag_words[override_total[OV_IW-1:0]] <= {entry_buffer[9], entry_buffer[8]};
            override_total <= override_total + OV_CW'(1);
          end
        end else if (entry_buffer[0] == madt_pkg::ENT_LAPIC_OVR && entry_buffer[1] >= 8'd12) begin
          lapic_base <= {entry_buffer[11], entry_buffer[10], entry_buffer[9], entry_buffer[8],
                         entry_buffer[7], entry_buffer[6], entry_buffer[5], entry_buffer[4]};
        end else begin
          boot_apic <= boot_apic;
        end
      end

      if (cmd.isa_step && !(isa_end || isa_hit)) ov_cnt <= ov_cnt + OV_CW'(1);

      if (cmd.gsi_load && !gsi_end) begin
        base_i <= rd_base;
        span   <= 5'(madt_pkg::PIN_WINDOW);
        j_cnt  <= '0;
      end

      if (cmd.gsi_scan) begin
        if (j_cnt != io_cnt && rd_base > base_i && diff < {27'd0, span}) span <= diff[4:0];
        j_cnt <= j_cnt + IO_CW'(1);
      end

      if (cmd.gsi_test && !gsi_hit) io_cnt <= io_cnt + IO_CW'(1);
    end
  end

  // result registers: common fields first, then per-kind answers
  logic res_wr;
  assign res_wr = cmd.fin || (cmd.isa_step && (isa_end || isa_hit)) ||
                  (cmd.gsi_load && gsi_end) || (cmd.gsi_test && gsi_hit);

  always_ff @(posedge clk) begin
    if (res_wr) begin
      lapic_addr     <= lapic_base;
      legacy_pic     <= pic_flag;
      bsp_apic_id    <= boot_apic;
      table_valid    <= 1'b0;
      found          <= 1'b0;
      resolved_gsi   <= '0;
      override_flags <= '0;
      ioapic_slot    <= '0;
      io_apic_id     <= '0;
      ioapic_address <= '0;
      pin_number     <= '0;
      if (cmd.fin) begin
        result_kind <= madt_pkg::RK_TABLE;
        table_valid <= (running_sum == 8'd0) && (table_length >= 32'd8) &&
                       (ioapic_total != '0) && (lapic_base != 64'd0);
      end
      if (cmd.isa_step) begin
        result_kind    <= madt_pkg::RK_ISA;
        found          <= isa_hit;
        resolved_gsi   <= isa_hit ? override_gsis[ov_idx] : {24'd0, irq_q};
        override_flags <= isa_hit ? override_flag_words[ov_idx] : 16'd0;
      end
      if (cmd.gsi_load || cmd.gsi_test) begin
        result_kind <= madt_pkg::RK_GSI;
      end
      if (cmd.gsi_test) begin
        found          <= 1'b1;
        ioapic_slot    <= 3'(io_cnt);
        io_apic_id     <= io_apic_ids[io_idx];
        ioapic_address <= ioapic_addrs[io_idx];
        pin_number     <= 5'(gsi_q - base_i);
      end
    end
  end

endmodule

// ===== src/madt_interrupt_routing_unit.sv =====
`timescale 1ns / 1ps
// Top level of the MADT interrupt routing unit.
// Depends on madt_pkg, madt_ctrl and madt_dp.
//
// Usage:
//   A request is accepted on a rising edge with start high and busy low.
//   kind selects a table byte (first_byte restarts parsing), an ISA IRQ
//   lookup through the interrupt source overrides, or a GSI lookup that
//   finds the covering IOAPIC window (24 pins or up to the next base).
//   Each result sits on the result ports for exactly one cycle with
//   strobe high; the receiver cannot stall, so capture it then.
// Steps:
//   Table byte: no result; the last table byte steps through parse,
//   optional entry apply, finish and result.
//   ISA lookup: up to K stored overrides walked one per cycle.
//   GSI lookup: per IOAPIC tried a load, N base compares in the shared
//   comparator and a window test, N the stored IOAPIC count; then result.
//   The single read port on the IOAPIC base table sets the GSI rate.
// Reset: rst clears the parser, table counts and sequencer; tables are
//   not swept, entries are only read below their counts.
module madt_interrupt_routing_unit #(
  parameter int MAX_IOAPICS   = madt_pkg::DEF_MAX_IOAPICS,
  parameter int MAX_OVERRIDES = madt_pkg::DEF_MAX_OVERRIDES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic        first_byte,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  isa_irq,
  input  logic [31:0] gsi_query,
  output logic        strobe,
  output logic [1:0]  result_kind,
  output logic        table_valid,
  output logic [63:0] lapic_addr,
  output logic        legacy_pic,
  output logic [7:0]  bsp_apic_id,
  output logic        found,
  output logic [31:0] resolved_gsi,
  output logic [15:0] override_flags,
  output logic [2:0]  ioapic_slot,
  output logic [7:0]  io_apic_id,
  output logic [31:0] ioapic_address,
  output logic [4:0]  pin_number
);

  madt_pkg::madt_cmd_t cmd;
  madt_pkg::madt_sts_t sts;

  // sequencer: one state per parse/walk step
  madt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  // datapath: holds tables and builds the result
  madt_dp #(
    .MAX_IOAPICS   (MAX_IOAPICS),
    .MAX_OVERRIDES (MAX_OVERRIDES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (kind),
    .first_byte     (first_byte),
    .data_byte      (data_byte),
    .isa_irq        (isa_irq),
    .gsi_query      (gsi_query),
    .result_kind    (result_kind),
    .table_valid    (table_valid),
    .lapic_addr     (lapic_addr),
    .legacy_pic     (legacy_pic),
    .bsp_apic_id    (bsp_apic_id),
    .found          (found),
    .resolved_gsi   (resolved_gsi),
    .override_flags (override_flags),
    .ioapic_slot    (ioapic_slot),
    .io_apic_id     (io_apic_id),
    .ioapic_address (ioapic_address),
    .pin_number     (pin_number)
  );

endmodule

// ===== src/madt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the MADT interrupt routing unit, bound to the top.
// Depends on madt_pkg and madt_interrupt_routing_unit.
module madt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  kind,
  input logic        strobe,
  input logic [1:0]  result_kind,
  input logic        table_valid,
  input logic        found,
  input logic [4:0]  pin_number
);

  // a result only comes out of a request in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe without busy");

  // the unit is free right after a result
  a_free_after: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !busy) else $error("still busy after result");

  // an accepted request of a known kind holds the unit
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == madt_pkg::KIND_BYTE || kind == madt_pkg::KIND_ISA ||
                        kind == madt_pkg::KIND_GSI)) |=> (busy || strobe))
    else $error("accept lost");

  // query answers never carry table validity; GSI pin bounded by window
  a_query_fields: assert property (@(posedge clk) disable iff (rst)
    (strobe && result_kind != madt_pkg::RK_TABLE) |->
      (!table_valid && (pin_number < 5'(madt_pkg::PIN_WINDOW))))
    else $error("bad query fields");

  // a GSI miss carries no pin
  a_gsi_miss: assert property (@(posedge clk) disable iff (rst)
    (strobe && result_kind == madt_pkg::RK_GSI && !found) |-> (pin_number == 5'd0))
    else $error("pin on GSI miss");

endmodule

bind madt_interrupt_routing_unit madt_checker u_madt_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .kind        (kind),
  .strobe      (strobe),
  .result_kind (result_kind),
  .table_valid (table_valid),
  .found       (found),
  .pin_number  (pin_number)
);

// ===== sim/madt_interrupt_routing_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for madt_interrupt_routing_unit: streams MADT images and
// ISA/GSI lookups, predicts every result in-bench. Depends on madt_pkg and the RTL.
module madt_interrupt_routing_unit_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_GOAL   = 1550;

  typedef struct {
    logic [1:0]  kind;
    logic        first;
    logic [7:0]  data;
    logic [7:0]  irq;
    logic [31:0] gsi;
  } request_t;

  typedef struct {
    logic [1:0]  kind;
    logic        valid;
    logic [63:0] lapic;
    logic        pic;
    logic [7:0]  bsp;
    logic        found;
    logic [31:0] rgsi;
    logic [15:0] oflags;
    logic [2:0]  slot;
    logic [7:0]  id;
    logic [31:0] addr;
    logic [4:0]  pin;
  } answer_t;

  // one row of stimulus; typed rows carry an expected answer written by hand
  typedef struct {
    request_t r;
    bit       typed;
    answer_t  e;
  } row_t;

  logic        clk, rst, start, busy;
  logic [1:0]  kind;
  logic        first_byte;
  logic [7:0]  data_byte, isa_irq;
  logic [31:0] gsi_query;
  logic        strobe;
  logic [1:0]  result_kind;
  logic        table_valid, legacy_pic, found;
  logic [63:0] lapic_addr;
  logic [7:0]  bsp_apic_id, io_apic_id;
  logic [31:0] resolved_gsi, ioapic_address;
  logic [15:0] override_flags;
  logic [2:0]  ioapic_slot;
  logic [4:0]  pin_number;

  madt_interrupt_routing_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the parser and routing tables
  // ---------------------------------------------------------------------
  logic [31:0] sh_off, sh_len;
  logic [7:0]  sh_sum;
  logic [7:0]  sh_ent[16];
  int          sh_epos;
  bit          sh_stopped;
  logic [63:0] sh_lapic;
  logic        sh_pic;
  logic [7:0]  sh_bsp;
  logic [7:0]  sh_io_id[madt_pkg::DEF_MAX_IOAPICS];
  logic [31:0] sh_io_addr[madt_pkg::DEF_MAX_IOAPICS];
  logic [31:0] sh_io_base[madt_pkg::DEF_MAX_IOAPICS];
  int          sh_nio;
  logic [7:0]  sh_ov_src[madt_pkg::DEF_MAX_OVERRIDES];
  logic [31:0] sh_ov_gsi[madt_pkg::DEF_MAX_OVERRIDES];
  logic [15:0] sh_ov_flags[madt_pkg::DEF_MAX_OVERRIDES];
  int          sh_nov;

  row_t        plan[$];
  answer_t     pending[$];
  logic [7:0]  image[$];
  bit          failed;
  int          cycles;

  task automatic clear_tables();
    sh_off = '0; sh_len = '0; sh_sum = '0; sh_epos = 0; sh_stopped = 0;
    sh_lapic = '0; sh_pic = 0; sh_bsp = '0; sh_nio = 0; sh_nov = 0;
    foreach (sh_ent[i]) sh_ent[i] = '0;
  endtask

  function automatic logic [31:0] ent_word(int k);
    return {sh_ent[k+3], sh_ent[k+2], sh_ent[k+1], sh_ent[k]};
  endfunction

  // commit a completed entry to the tables
  task automatic commit_entry();
    logic [7:0] typ, len;
    typ = sh_ent[0];
    len = sh_ent[1];
    if (typ == madt_pkg::ENT_LAPIC && len >= 8) begin
      if (sh_ent[4][0] && sh_bsp == 0) sh_bsp = sh_ent[3];
    end else if (typ == madt_pkg::ENT_IOAPIC && len >= 12) begin
      if (sh_nio < madt_pkg::DEF_MAX_IOAPICS) begin
        sh_io_id[sh_nio]   = sh_ent[2];
        sh_io_addr[sh_nio] = ent_word(4);
        sh_io_base[sh_nio] = ent_word(8);
        sh_nio++;
      end
    end else if (typ == madt_pkg::ENT_OVERRIDE && len >= 10) begin
      if (sh_nov < madt_pkg::DEF_MAX_OVERRIDES) begin
        sh_ov_src[sh_nov]   = sh_ent[3];
        sh_ov_gsi[sh_nov]   = ent_word(4);
        sh_ov_flags[sh_nov] = {sh_ent[9], sh_ent[8]};
        sh_nov++;
      end
    end else if (typ == madt_pkg::ENT_LAPIC_OVR && len >= 12) begin
      sh_lapic = {ent_word(8), ent_word(4)};
    end
  endtask

  task automatic entry_byte(logic [7:0] b);
    int pos, elen;
    pos = sh_epos;
    if (pos < 16) sh_ent[pos] = b;
    if (pos == 0) begin
      sh_epos = 1;
    end else if (pos == 1 && b == 0) begin
      // zero-length entry: stop entry parsing for the rest of the table
      sh_stopped = 1;
    end else begin
      elen = sh_ent[1];
      if (elen < 2) elen = 2;
      if (pos + 1 >= elen) begin
        commit_entry();
        sh_epos = 0;
      end else begin
        sh_epos = pos + 1;
      end
    end
  endtask

  // advance the shadow state by one request and work out its answer
  task automatic route_request(input request_t r, output bit has, output answer_t o);
    logic [31:0] off, base, span;
    bit          hit;
    o = '{default: '0};
    has = 0;
    o.lapic = sh_lapic;
    o.pic = sh_pic;
    o.bsp = sh_bsp;
    case (r.kind)
      madt_pkg::KIND_BYTE: begin
        if (r.first) clear_tables();
        if (!(sh_off >= 8 && sh_off >= sh_len)) begin
          off = sh_off;
          sh_sum += r.data;
          if (off >= 4 && off <= 7) sh_len |= 32'(r.data) << (8 * (off - 4));
          else if (off >= 36 && off <= 39) sh_lapic |= 64'(r.data) << (8 * (off - 36));
          else if (off == 40) sh_pic = r.data[0];
          else if (off >= madt_pkg::ENTRY_START && !sh_stopped) entry_byte(r.data);
          sh_off = off + 1;
          if (off >= 7 && {1'b0, off} + 33'd1 >= {1'b0, sh_len}) begin
            has = 1;
            o.kind = madt_pkg::RK_TABLE;
            o.lapic = sh_lapic;
            o.pic = sh_pic;
            o.bsp = sh_bsp;
            o.valid = (sh_sum == 0 && sh_len >= 8 && sh_nio > 0 && sh_lapic != 0);
          end
        end
      end
      madt_pkg::KIND_ISA: begin
        has = 1;
        o.kind = madt_pkg::RK_ISA;
        o.rgsi = 32'(r.irq);
        for (int i = 0; i < sh_nov; i++) begin
          if (!o.found && sh_ov_src[i] == r.irq) begin
            o.found = 1;
            o.rgsi = sh_ov_gsi[i];
            o.oflags = sh_ov_flags[i];
          end
        end
      end
      madt_pkg::KIND_GSI: begin
        has = 1;
        o.kind = madt_pkg::RK_GSI;
        hit = 0;
        for (int i = 0; i < sh_nio; i++) begin
          base = sh_io_base[i];
          span = madt_pkg::PIN_WINDOW;
          for (int j = 0; j < sh_nio; j++)
            if (j != i && sh_io_base[j] > base && sh_io_base[j] - base < span)
              span = sh_io_base[j] - base;
          // window test without wraparound
          if (!hit && r.gsi >= base && {1'b0, r.gsi} < {1'b0, base} + {1'b0, span}) begin
            hit = 1;
            o.found = 1;
            o.slot = 3'(i);
            o.id = sh_io_id[i];
            o.addr = sh_io_addr[i];
            o.pin = 5'(r.gsi - base);
          end
        end
      end
      default: ;  // kind 3: dropped, no answer
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------
  function automatic request_t noise_fields(logic [1:0] k);
    request_t r;
    r.kind = k;
    r.first = 0;
    r.data = 8'($urandom);
    r.irq = 8'($urandom);
    r.gsi = $urandom;
    return r;
  endfunction

  task automatic add_row(request_t r, bit typed = 0, answer_t e = '{default: '0});
    row_t w;
    w.r = r;
    w.typed = typed;
    w.e = e;
    plan.push_back(w);
  endtask

  task automatic add_query(logic [1:0] k, logic [7:0] irq, logic [31:0] gsi,
                           bit typed = 0, answer_t e = '{default: '0});
    request_t r;
    r = noise_fields(k);
    r.irq = irq;
    r.gsi = gsi;
    add_row(r, typed, e);
  endtask

  task automatic add_byte(logic [7:0] b, bit first, bit typed = 0,
                          answer_t e = '{default: '0});
    request_t r;
    r = noise_fields(madt_pkg::KIND_BYTE);
    r.data = b;
    r.first = first;
    add_row(r, typed, e);
  endtask

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      1: return $urandom;
      2: return 24 * $urandom_range(0, 8);
      default: return 8 * $urandom_range(0, 20) + $urandom_range(0, 3);
    endcase
  endfunction

  // build one MADT image into image[]: header, random entries, length, checksum
  task automatic build_image(output logic [31:0] len_field);
    int n_ent, typ, len, at, total, sum_len;
    logic [7:0]  sum;
    logic [31:0] w;
    image.delete();
    for (int i = 0; i < madt_pkg::ENTRY_START; i++) image.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0)
      for (int i = 36; i < 40; i++) image[i] = 0;
    n_ent = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 26) : $urandom_range(0, 12);
    for (int k = 0; k < n_ent; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:     begin typ = madt_pkg::ENT_LAPIC;     len = 8;  end
        5, 6, 7, 8, 9, 10: begin typ = madt_pkg::ENT_IOAPIC;    len = 12; end
        11, 12, 13, 14:    begin typ = madt_pkg::ENT_OVERRIDE;  len = 10; end
        15, 16:            begin typ = madt_pkg::ENT_LAPIC_OVR; len = 12; end
        default:           begin typ = $urandom_range(3, 255); len = $urandom_range(2, 20); end
      endcase
      if ($urandom_range(0, 11) == 0) len = $urandom_range(0, 20);
      at = image.size();
      for (int i = 0; i < ((len < 2) ? 2 : len); i++) image.push_back(8'($urandom));
      image[at] = 8'(typ);
      image[at + 1] = 8'(len);
      if (typ == madt_pkg::ENT_IOAPIC && len >= 12) begin
        w = pick_base();
        for (int i = 0; i < 4; i++) image[at + 8 + i] = w[8*i +: 8];
      end
      if (typ == madt_pkg::ENT_OVERRIDE && len >= 10 && $urandom_range(0, 1))
        image[at + 3] = 8'($urandom_range(0, 15));
    end
    total = image.size();
    case ($urandom_range(0, 19))
      0:       len_field = $urandom_range(0, 60);
      1, 2:    len_field = total - $urandom_range(1, 6);
      3:       len_field = {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
      default: len_field = total;
    endcase
    for (int i = 0; i < 4; i++) image[4 + i] = len_field[8*i +: 8];
    // fix the checksum so the covered bytes sum to zero, sometimes not
    sum_len = (len_field < 8) ? 8 : ((len_field > total) ? total : len_field);
    sum = 0;
    for (int i = 0; i < sum_len; i++) if (i != 9) sum += image[i];
    image[9] = -sum;
    if ($urandom_range(0, 9) == 0) image[9] ^= 8'($urandom_range(1, 255));
  endtask

  task automatic add_queries(int n);
    logic [31:0] g;
    for (int q = 0; q < n; q++) begin
      if ($urandom_range(0, 1)) begin
        add_query(madt_pkg::KIND_ISA, (sh_nov > 0 && $urandom_range(0, 1))
                  ? sh_ov_src[$urandom_range(0, sh_nov - 1)] : 8'($urandom), '0);
      end else begin
        g = $urandom;
        if (sh_nio > 0 && $urandom_range(0, 4) != 0) begin
          g = sh_io_base[$urandom_range(0, sh_nio - 1)];
          g = g + $urandom_range(0, 30) - ($urandom_range(0, 4) == 0 ? 32'd2 : 32'd0);
        end
        add_query(madt_pkg::KIND_GSI, 8'($urandom), g);
      end
    end
  endtask

  task automatic build_plan();
    answer_t e;
    bit      has;
    answer_t dummy;
    // after reset: nothing stored, lookups come back empty
    e = '{default: '0}; e.kind = madt_pkg::RK_ISA; e.rgsi = 32'd0;
    add_query(madt_pkg::KIND_ISA, 8'h00, '0, 1, e);
    e.rgsi = 32'hFF;
    add_query(madt_pkg::KIND_ISA, 8'hFF, '0, 1, e);
    e = '{default: '0}; e.kind = madt_pkg::RK_GSI;
    add_query(madt_pkg::KIND_GSI, '0, 32'h0, 1, e);
    add_query(madt_pkg::KIND_GSI, '0, 32'hFFFF_FFFF, 1, e);
    add_row(noise_fields(2'd3));   // unused kind: dropped
    // header with length zero: finishes at byte 7, invalid
    e = '{default: '0}; e.kind = madt_pkg::RK_TABLE;
    for (int i = 0; i < 8; i++) add_byte(8'h00, i == 0, i == 7, e);
    add_byte(8'hA5, 0);            // past the end: ignored
    add_query(madt_pkg::KIND_GSI, '0, 32'h5AA5_A5A5);
    // six all-ones bytes, length field 0x0000FFFF, truncated at first_byte of the next table
    for (int i = 0; i < 6; i++) add_byte(8'hFF, i == 0);
    // length 8 with bad checksum and no IOAPIC
    for (int i = 0; i < 8; i++) add_byte((i == 4) ? 8'd8 : 8'h00, i == 0, i == 7, e);
    // walk a shadow pass over the directed rows so random lookups see real tables
    foreach (plan[i]) route_request(plan[i].r, has, dummy);
    // random part: images with random content, some malformed, lookups interleaved
    while (plan.size() < ITEM_GOAL) begin
      logic [31:0] lf;
      build_image(lf);
      foreach (image[i]) begin
        add_byte(image[i], i == 0);
        route_request(plan[$].r, has, dummy);
        if ($urandom_range(0, 24) == 0) begin
          add_queries(1);
          route_request(plan[$].r, has, dummy);
        end
        if ($urandom_range(0, 60) == 0) begin
          add_row(noise_fields(2'd3));
          route_request(plan[$].r, has, dummy);
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        add_byte(8'($urandom), 0);   // trailing byte, normally ignored
        route_request(plan[$].r, has, dummy);
      end
      for (int q = $urandom_range(8, 30); q > 0; q--) begin
        add_queries(1);
        route_request(plan[$].r, has, dummy);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------
  initial begin
    bit      has;
    answer_t o;
    int      quiet;
    start <= 0; kind <= madt_pkg::KIND_BYTE; first_byte <= 0; data_byte <= '0;
    isa_irq <= '0; gsi_query <= '0; rst <= 1;
    failed = 0;
    build_plan();
    clear_tables();   // the bench replays the plan from a clean shadow
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    quiet = 0;
    foreach (plan[n]) begin
      // hold off in random bursts; the final tenth of the run goes flat out
      if (n < plan.size() * 9 / 10) begin
        if (quiet > 0) quiet--;
        else if ($urandom_range(0, 6) == 0) begin
          start <= 0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end else if ($urandom_range(0, 40) == 0) quiet = $urandom_range(20, 80);
      end
      start <= 1;
      kind <= plan[n].r.kind;
      first_byte <= plan[n].r.first;
      data_byte <= plan[n].r.data;
      isa_irq <= plan[n].r.irq;
      gsi_query <= plan[n].r.gsi;
      @(posedge clk);
      while (busy) @(posedge clk);
      // accepted at this edge
      route_request(plan[n].r, has, o);
      if (plan[n].typed) pending.push_back(plan[n].e);
      else if (has) pending.push_back(o);
    end
    start <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      failed = 1;
    end
  endfunction

  always @(posedge clk) begin
    answer_t e;
    if (!rst && strobe) begin
      if (pending.size() == 0) begin
        $error("unexpected result, result_kind %0d", result_kind);
        failed = 1;
      end else begin
        e = pending.pop_front();
        check_field("result_kind", e.kind, result_kind);
        check_field("table_valid", e.valid, table_valid);
        check_field("lapic_addr", e.lapic, lapic_addr);
        check_field("legacy_pic", e.pic, legacy_pic);
        check_field("bsp_apic_id", e.bsp, bsp_apic_id);
        check_field("found", e.found, found);
        check_field("resolved_gsi", e.rgsi, resolved_gsi);
        check_field("override_flags", e.oflags, override_flags);
        check_field("ioapic_slot", e.slot, ioapic_slot);
        check_field("io_apic_id", e.id, io_apic_id);
        check_field("ioapic_address", e.addr, ioapic_address);
        check_field("pin_number", e.pin, pin_number);
      end
    end
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
